/* sv/apfp_pkg.sv */
`timescale 1ns / 1ps
// Package: ring sizes, operation codes and register indexes for the audio playout ring.
package apfp_pkg;

  localparam int RING_SAMPLES = 16384;
  localparam int IDX_W        = $clog2(RING_SAMPLES);
  localparam int CNT_W        = $clog2(RING_SAMPLES + 1);
  localparam int BANK_DEPTH   = RING_SAMPLES / 2;
  localparam int BANK_AW      = IDX_W - 1;

  localparam int SAMPLE_W = 16;
  localparam int FILL_W   = 15;
  localparam int TICK_W   = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [CNT_W-1:0]  RING_CNT  = CNT_W'(RING_SAMPLES);
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(RING_SAMPLES - 1);
  localparam logic [BANK_AW-1:0] PAIR_LAST = BANK_AW'(BANK_DEPTH - 1);
  localparam logic [TICK_W-1:0] IDLE_MAX  = '1;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_PULL = 2'd1,
    OP_TICK = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PREBUF = 1'b0,
    CFG_GIVEUP = 1'b1
  } cfg_idx_e;

endpackage

/* sv/apfp_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module apfp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/audio_playout_fifo_prebuffer_top.sv */
`timescale 1ns / 1ps
// Top level: audio playout ring with prebuffer threshold and give-up timer.
//
// Requests enter on start with op_i and sample_word_i; busy is always low, so a
// request is taken in every cycle that start is high. op_i selects push (store
// one sample), pull (deliver one stereo frame) or tick (advance the idle timer).
// Every request gives exactly one result: done_o is high for one cycle, registered
// via in_vld_q and res_vld_q, with frame_valid_o, left/right samples, dropped_o,
// fill_level_o and waiting_o. Results follow requests in order, one per cycle.
// The sample ring is split into an even bank and an odd bank; a pull always
// starts on an even slot, so both samples of a frame come from one read of
// each bank, and the banks' registered read lines up with res_vld_q.
// Configuration writes go through cfg_valid_i/cfg_ready_o (always ready) with
// cfg_index_i selecting the prebuffer threshold or the give-up limit; write
// only while no request is in flight. Reset empties the ring, arms
// prebuffering, saturates the idle timer and loads the default register values.
// The receiver cannot stall; each result must be taken in its cycle.
module audio_playout_fifo_prebuffer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        op_i,
  input  logic [apfp_pkg::SAMPLE_W-1:0]     sample_word_i,
  output logic                              done_o,
  output logic                              frame_valid_o,
  output logic signed [apfp_pkg::SAMPLE_W-1:0] left_sample_o,
  output logic signed [apfp_pkg::SAMPLE_W-1:0] right_sample_o,
  output logic                              dropped_o,
  output logic [apfp_pkg::FILL_W-1:0]       fill_level_o,
  output logic                              waiting_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [apfp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [apfp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int CNT_W   = apfp_pkg::CNT_W;
  localparam int IDX_W   = apfp_pkg::IDX_W;
  localparam int BANK_AW = apfp_pkg::BANK_AW;
  localparam int TICK_W  = apfp_pkg::TICK_W;
  localparam int FILL_W  = apfp_pkg::FILL_W;
  localparam int SAMPLE_W = apfp_pkg::SAMPLE_W;

  logic                in_vld_q;
  logic [1:0]          op_q;
  logic [SAMPLE_W-1:0] word_q;

  logic [CNT_W-1:0]   held_q, held_d;
  logic [IDX_W-1:0]   widx_q, widx_d;
  logic [BANK_AW-1:0] rpair_q, rpair_d;
  logic               flag_q, flag_d;
  logic [TICK_W-1:0]  idle_q, idle_d;
  logic [FILL_W-1:0]  pb_q;
  logic [TICK_W-1:0]  gu_q;

  logic              res_vld_q;
  logic              fv_q, fv_d;
  logic              drop_q, drop_d;
  logic [FILL_W-1:0] fill_q;
  logic              wait_q;

  logic                store;
  logic                hold;
  logic                we_even, we_odd;
  logic [SAMPLE_W-1:0] even_rdata, odd_rdata;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q   <= op_i;
      word_q <= sample_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_q <= FILL_W'(2646);
      gu_q <= TICK_W'(50000);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        apfp_pkg::CFG_PREBUF: pb_q <= cfg_data_i[FILL_W-1:0];
        apfp_pkg::CFG_GIVEUP: gu_q <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    held_d  = held_q;
    widx_d  = widx_q;
    rpair_d = rpair_q;
    flag_d  = flag_q;
    idle_d  = idle_q;
    fv_d    = 1'b0;
    drop_d  = 1'b0;
    store   = 1'b0;
    hold    = 1'b0;
    if (in_vld_q) begin
      unique case (op_q)
        apfp_pkg::OP_PUSH: begin
          idle_d = '0;
          if (held_q >= apfp_pkg::RING_CNT) begin
            drop_d = 1'b1;
          end else begin
            store  = 1'b1;
            widx_d = (widx_q == apfp_pkg::IDX_LAST) ? '0 : widx_q + IDX_W'(1);
            held_d = held_q + CNT_W'(1);
          end
        end
        apfp_pkg::OP_PULL: begin
          if (held_q == '0) begin
            flag_d = 1'b1;
          end else begin
            if (flag_q) begin
              if ((32'(held_q) < 32'(pb_q)) && (idle_q < gu_q)) begin
                hold = 1'b1;
              end else begin
                flag_d = 1'b0;
              end
            end
            if (!hold && (held_q >= CNT_W'(2))) begin
              fv_d    = 1'b1;
              held_d  = held_q - CNT_W'(2);
              rpair_d = (rpair_q == apfp_pkg::PAIR_LAST) ? '0 : rpair_q + BANK_AW'(1);
            end
          end
        end
        apfp_pkg::OP_TICK: begin
          if (idle_q != apfp_pkg::IDLE_MAX) begin
            idle_d = idle_q + TICK_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      widx_q    <= '0;
      rpair_q   <= '0;
      flag_q    <= 1'b1;
      idle_q    <= apfp_pkg::IDLE_MAX;
      res_vld_q <= 1'b0;
      fv_q      <= 1'b0;
      drop_q    <= 1'b0;
      fill_q    <= '0;
      wait_q    <= 1'b1;
    end else begin
      held_q    <= held_d;
      widx_q    <= widx_d;
      rpair_q   <= rpair_d;
      flag_q    <= flag_d;
      idle_q    <= idle_d;
      res_vld_q <= in_vld_q;
      fv_q      <= fv_d;
      drop_q    <= drop_d;
      fill_q    <= FILL_W'(held_d);
      wait_q    <= flag_d;
    end
  end

  assign we_even = store && !widx_q[0];
  assign we_odd  = store && widx_q[0];

  apfp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (apfp_pkg::BANK_DEPTH)
  ) u_ram_even (
    .clk_i   (clk_i),
    .we_i    (we_even),
    .waddr_i (widx_q[IDX_W-1:1]),
    .wdata_i (word_q),
    .raddr_i (rpair_q),
    .rdata_o (even_rdata)
  );

  apfp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (apfp_pkg::BANK_DEPTH)
  ) u_ram_odd (
    .clk_i   (clk_i),
    .we_i    (we_odd),
    .waddr_i (widx_q[IDX_W-1:1]),
    .wdata_i (word_q),
    .raddr_i (rpair_q),
    .rdata_o (odd_rdata)
  );

  assign done_o         = res_vld_q;
  assign frame_valid_o  = res_vld_q && fv_q;
  assign left_sample_o  = (res_vld_q && fv_q) ? $signed(even_rdata) : '0;
  assign right_sample_o = (res_vld_q && fv_q) ? $signed(odd_rdata) : '0;
  assign dropped_o      = res_vld_q && drop_q;
  assign fill_level_o   = fill_q;
  assign waiting_o      = wait_q;

  a_no_frame_and_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(frame_valid_o && dropped_o))
    else $error("frame and drop reported for one request");

  a_held_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= apfp_pkg::RING_CNT)
    else $error("fill count beyond ring size");

  a_frame_takes_two : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o |-> (held_q + CNT_W'(2) == $past(held_q)))
    else $error("frame delivered without removing two samples");

  a_frame_not_waiting : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o |-> !waiting_o)
    else $error("frame delivered while prebuffering");

endmodule

/* sim/audio_playout_fifo_prebuffer_top_test.sv */
`timescale 1ns / 1ps
// Testbench: drives push, pull and tick requests into the playout ring and checks every result.
module audio_playout_fifo_prebuffer_top_test;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]                    op;
    logic [apfp_pkg::SAMPLE_W-1:0] word;
  } play_req_t;

  typedef struct packed {
    logic                                 frame_valid;
    logic signed [apfp_pkg::SAMPLE_W-1:0] left;
    logic signed [apfp_pkg::SAMPLE_W-1:0] right;
    logic                                 dropped;
    logic [apfp_pkg::FILL_W-1:0]          fill;
    logic                                 waiting;
  } play_res_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] op_i = apfp_pkg::OP_PUSH;
  logic [apfp_pkg::SAMPLE_W-1:0] sample_word_i = '0;
  logic done_o;
  logic frame_valid_o;
  logic signed [apfp_pkg::SAMPLE_W-1:0] left_sample_o;
  logic signed [apfp_pkg::SAMPLE_W-1:0] right_sample_o;
  logic dropped_o;
  logic [apfp_pkg::FILL_W-1:0] fill_level_o;
  logic waiting_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [apfp_pkg::CFG_IDX_W-1:0] cfg_index_i = apfp_pkg::CFG_PREBUF;
  logic [apfp_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  audio_playout_fifo_prebuffer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .sample_word_i  (sample_word_i),
    .done_o         (done_o),
    .frame_valid_o  (frame_valid_o),
    .left_sample_o  (left_sample_o),
    .right_sample_o (right_sample_o),
    .dropped_o      (dropped_o),
    .fill_level_o   (fill_level_o),
    .waiting_o      (waiting_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  play_req_t req_q[$];
  play_res_t frame_exp_q[$];

  logic [apfp_pkg::SAMPLE_W-1:0] ring_mem [apfp_pkg::RING_SAMPLES];
  logic [apfp_pkg::IDX_W-1:0]    rd_ptr;
  logic [apfp_pkg::IDX_W-1:0]    wr_ptr;
  logic [apfp_pkg::CNT_W-1:0]    held;
  logic                          armed;
  logic [apfp_pkg::TICK_W-1:0]   idle_cnt;
  logic [apfp_pkg::FILL_W-1:0]   threshold;
  logic [apfp_pkg::TICK_W-1:0]   giveup;

  int idle_pct = 0;
  int calm_left = 0;
  int reqs_sent = 0;
  int results_seen = 0;
  int frames_seen = 0;
  int drops_seen = 0;
  int holds_seen = 0;
  int reg_writes = 0;
  int errors = 0;
  play_req_t next_req;

  function automatic logic [apfp_pkg::SAMPLE_W-1:0] pop_sample();
    logic [apfp_pkg::SAMPLE_W-1:0] v;
    v = ring_mem[rd_ptr];
    rd_ptr = (rd_ptr == apfp_pkg::IDX_LAST) ? '0 : rd_ptr + 1'b1;
    held = held - 1'b1;
    return v;
  endfunction

  function automatic void predict_playout(logic [1:0] op, logic [apfp_pkg::SAMPLE_W-1:0] word);
    play_res_t r;
    logic hold;
    r = '0;
    hold = 1'b0;
    case (op)
      apfp_pkg::OP_PUSH: begin
        idle_cnt = '0;
        if (held >= apfp_pkg::RING_CNT) begin
          r.dropped = 1'b1;
        end else begin
          ring_mem[wr_ptr] = word;
          wr_ptr = (wr_ptr == apfp_pkg::IDX_LAST) ? '0 : wr_ptr + 1'b1;
          held = held + 1'b1;
        end
      end
      apfp_pkg::OP_PULL: begin
        if (held == '0) begin
          armed = 1'b1;
        end else begin
          if (armed) begin
            if (held < apfp_pkg::CNT_W'(threshold) && idle_cnt < giveup) hold = 1'b1;
            else armed = 1'b0;
          end
          if (!hold && held >= apfp_pkg::CNT_W'(2)) begin
            r.left = pop_sample();
            r.right = pop_sample();
            r.frame_valid = 1'b1;
          end
        end
      end
      apfp_pkg::OP_TICK: begin
        if (idle_cnt != apfp_pkg::IDLE_MAX) idle_cnt = idle_cnt + 1'b1;
      end
      default: begin
      end
    endcase
    r.fill = held[apfp_pkg::FILL_W-1:0];
    r.waiting = armed;
    frame_exp_q.push_back(r);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predict_playout(op_i, sample_word_i);
        reqs_sent++;
      end
      if (!(start && busy)) begin
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 99) == 0) calm_left = $urandom_range(20, 60);
        if (req_q.size() > 0 && (calm_left > 0 || $urandom_range(0, 99) >= idle_pct)) begin
          next_req = req_q.pop_front();
          start <= 1'b1;
          op_i <= next_req.op;
          sample_word_i <= next_req.word;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    play_res_t got;
    play_res_t want;
    if (rst_ni && done_o) begin
      got = {frame_valid_o, left_sample_o, right_sample_o, dropped_o, fill_level_o, waiting_o};
      results_seen++;
      if (frame_valid_o) frames_seen++;
      if (dropped_o) drops_seen++;
      if (waiting_o) holds_seen++;
      if (frame_exp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result at %0t ns", $realtime);
      end else begin
        want = frame_exp_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("result %0d mismatch: expected fv=%0b l=%0d r=%0d drop=%0b fill=%0d wait=%0b",
                     results_seen, want.frame_valid, want.left, want.right, want.dropped,
                     want.fill, want.waiting);
            $display("  got fv=%0b l=%0d r=%0d drop=%0b fill=%0d wait=%0b",
                     got.frame_valid, got.left, got.right, got.dropped, got.fill, got.waiting);
          end
        end
      end
    end
  end

  task automatic add_req(logic [1:0] op, logic [apfp_pkg::SAMPLE_W-1:0] word);
    play_req_t r;
    r.op = op;
    r.word = word;
    req_q.push_back(r);
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (req_q.size() != 0 || start || frame_exp_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(apfp_pkg::cfg_idx_e idx, logic [apfp_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    if (idx == apfp_pkg::CFG_PREBUF) threshold = data[apfp_pkg::FILL_W-1:0];
    else giveup = data[apfp_pkg::TICK_W-1:0];
    reg_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_random(int n);
    int left;
    int k;
    left = n;
    while (left > 0) begin
      case ($urandom_range(0, 9))
        7, 8: begin
          add_req(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
          left--;
        end
        9: begin
          case ($urandom_range(0, 3))
            0: add_req(apfp_pkg::OP_PUSH, 16'h0000);
            1: add_req(apfp_pkg::OP_PUSH, 16'hFFFF);
            2: add_req(apfp_pkg::OP_PUSH, 16'h8000);
            default: add_req(apfp_pkg::OP_PUSH, 16'h7FFF);
          endcase
          left--;
        end
        default: begin
          k = $urandom_range(1, 12);
          repeat (k) add_req(apfp_pkg::OP_PUSH, 16'($urandom_range(0, 65535)));
          left -= k;
          k = $urandom_range(0, 4);
          repeat (k) add_req(apfp_pkg::OP_TICK, 16'($urandom_range(0, 65535)));
          left -= k;
          k = $urandom_range(1, 8);
          repeat (k) add_req(apfp_pkg::OP_PULL, 16'($urandom_range(0, 65535)));
          left -= k;
        end
      endcase
    end
  endtask

  function automatic logic [apfp_pkg::CFG_DATA_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'd16384;
      2: return 24'd2646;
      default: return 24'($urandom_range(0, 24));
    endcase
  endfunction

  function automatic logic [apfp_pkg::CFG_DATA_W-1:0] pick_giveup();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'd50000;
      default: return 24'($urandom_range(0, 12));
    endcase
  endfunction

  initial begin
    #20_000_000;
    $display("timeout: %0d results still expected", frame_exp_q.size());
    $display("audio_playout_fifo_prebuffer_top_test: FAIL");
    $finish;
  end

  initial begin
    int pct [4];
    pct = '{0, 65, 37, 0};
    rd_ptr = '0;
    wr_ptr = '0;
    held = '0;
    armed = 1'b1;
    idle_cnt = apfp_pkg::IDLE_MAX;
    threshold = apfp_pkg::FILL_W'(2646);
    giveup = apfp_pkg::TICK_W'(50000);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // hold on defaults: saturated tick, empty pull, unused op
    add_req(apfp_pkg::OP_TICK, 16'h0000);
    add_req(apfp_pkg::OP_PULL, 16'hFFFF);
    add_req(OP_UNUSED, 16'h0000);
    add_req(apfp_pkg::OP_PUSH, 16'h0000);
    add_req(apfp_pkg::OP_PUSH, 16'hFFFF);
    add_req(apfp_pkg::OP_PULL, 16'h0000);
    add_req(OP_UNUSED, 16'hFFFF);
    add_req(apfp_pkg::OP_PUSH, 16'h8000);
    add_req(apfp_pkg::OP_PUSH, 16'h7FFF);
    add_req(apfp_pkg::OP_PUSH, 16'h1234);
    add_req(apfp_pkg::OP_PULL, 16'h0000);
    repeat (3) add_req(apfp_pkg::OP_TICK, 16'h0000);
    add_req(apfp_pkg::OP_PULL, 16'h0000);
    drain();

    // release on threshold, single sample, rearm, release on give-up
    write_reg(apfp_pkg::CFG_PREBUF, 24'd4);
    write_reg(apfp_pkg::CFG_GIVEUP, 24'd2);
    add_req(apfp_pkg::OP_PULL, 16'h0000);
    add_req(apfp_pkg::OP_PULL, 16'h0000);
    add_req(apfp_pkg::OP_PULL, 16'h0000);
    add_req(apfp_pkg::OP_PUSH, 16'h00FF);
    add_req(apfp_pkg::OP_PULL, 16'h0000);
    add_req(apfp_pkg::OP_PULL, 16'h0000);
    add_req(apfp_pkg::OP_PUSH, 16'hA55A);
    add_req(apfp_pkg::OP_PUSH, 16'h5AA5);
    add_req(apfp_pkg::OP_PULL, 16'h0000);
    repeat (2) add_req(apfp_pkg::OP_TICK, 16'h0000);
    add_req(apfp_pkg::OP_PULL, 16'h0000);
    drain();

    // fill past the threshold, drain to empty and rearm
    write_reg(apfp_pkg::CFG_PREBUF, 24'd32);
    write_reg(apfp_pkg::CFG_GIVEUP, 24'hFFFFFF);
    repeat (40) add_req(apfp_pkg::OP_PUSH, 16'($urandom_range(0, 65535)));
    add_req(apfp_pkg::OP_TICK, 16'h0000);
    repeat (22) add_req(apfp_pkg::OP_PULL, 16'h0000);
    drain();

    write_reg(apfp_pkg::CFG_PREBUF, 24'd0);
    write_reg(apfp_pkg::CFG_GIVEUP, 24'd0);
    add_random(60);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_reg(apfp_pkg::CFG_PREBUF, pick_threshold());
      write_reg(apfp_pkg::CFG_GIVEUP, pick_giveup());
      idle_pct = pct[p];
      add_random(200);
      drain();
    end

    idle_pct = 0;
    repeat (6) @(posedge clk_i);
    $display("covered %0d requests, %0d frames, %0d drops, %0d held results, %0d reg writes",
             reqs_sent, frames_seen, drops_seen, holds_seen, reg_writes);
    $display("checked %0d results, %0d mismatches", results_seen, errors);
    if (errors == 0 && frame_exp_q.size() == 0) begin
      $display("audio_playout_fifo_prebuffer_top_test: PASS");
    end else begin
      $display("audio_playout_fifo_prebuffer_top_test: FAIL");
    end
    $finish;
  end

endmodule
